// File: hw/rtl/mric_pkg.sv
// Package: constants, request/result structs and codes for the mixed-radix index converter
package mric_pkg;
	localparam int MAX_DIMS = 4;
	localparam int IDX_W    = 64;
	localparam int CRD_W    = 32;
	localparam int DIMS_W   = 3;
	localparam int NSTEP    = MAX_DIMS * IDX_W;

	localparam logic [2:0] REG_NUM_DIMS = 3'd0;
	localparam logic [2:0] REG_STRIDE_0 = 3'd1;
	localparam logic [2:0] REG_STRIDE_3 = 3'd4;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_TOO_MANY    = 2'd1,
		STATUS_ZERO_STRIDE = 2'd2
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [2:0]        coord_count;
		logic [CRD_W-1:0]  in_coord_0;
		logic [CRD_W-1:0]  in_coord_1;
		logic [CRD_W-1:0]  in_coord_2;
		logic [CRD_W-1:0]  in_coord_3;
		logic [IDX_W-1:0]  in_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  out_index;
		logic [CRD_W-1:0]  out_coord_0;
		logic [CRD_W-1:0]  out_coord_1;
		logic [CRD_W-1:0]  out_coord_2;
		logic [CRD_W-1:0]  out_coord_3;
		logic [1:0]        status;
	} res_t;

	typedef struct packed {
		logic              mode;
		status_t           st;
		logic [IDX_W-1:0]  rem;
	} front_t;

	typedef struct packed {
		logic                           mode;
		status_t                        st;
		logic [IDX_W-1:0]               idx;
		logic [IDX_W-1:0]               rem;
		logic [IDX_W-1:0]               r;
		logic [IDX_W-1:0]               rh;
		logic [CRD_W-1:0]               q;
		logic [MAX_DIMS-1:0][CRD_W-1:0] crd;
	} div_t;
endpackage

// File: hw/rtl/mixed_radix_index_convert_unit.sv
// Top level: pipelined coordinate/linear-index converter with stride configuration
//
// Usage:
//   in_valid/in_ready carry one request (req_t); out_valid/out_ready carry one
//   result (res_t). A request is taken on an edge where valid and ready are high.
//   cfg_we/cfg_idx/cfg_wdata write num_dims (index 0) and stride_0..3 (1..4);
//   write only while no request is in flight.
//   Throughput: one request per cycle while the skid register is empty. The depth
//   is set by the restoring divider: one quotient bit per stage, 64 stages per
//   dimension, four dimensions, after five stages of input checks, 32x32 partial
//   products and the index adder tree.
//   Reset clears all valid bits, num_dims to 0 and every stride to 1.
//   When the receiver stalls, the result moves into a one-entry skid register;
//   while that register is full the pipeline holds and in_ready is low.
module mixed_radix_index_convert_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mric_pkg::req_t        in_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mric_pkg::res_t        out_res,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [mric_pkg::IDX_W-1:0] cfg_wdata
);
	import mric_pkg::*;

	logic [DIMS_W-1:0]            num_dims_q;
	logic [IDX_W-1:0]             stride_q [MAX_DIMS];
	logic [DIMS_W-1:0]            dims;
	logic                         en;
	logic                         skid_v_q;
	res_t                         skid_q;
	res_t                         fmt;

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	front_t                       fr_s1, fr_s2, fr_s3, fr_s4, fr_s5;
	logic [MAX_DIMS-1:0][CRD_W-1:0] c_s1;
	logic [IDX_W-1:0]             plo_s2 [MAX_DIMS];
	logic [CRD_W-1:0]             phi_s2 [MAX_DIMS];
	logic [IDX_W-1:0]             term_s3 [MAX_DIMS];
	logic [IDX_W-1:0]             sum_s4 [2];
	logic [IDX_W-1:0]             idx_s5;

	logic                         dv_v_s [NSTEP+1];
	div_t                         dv_s   [NSTEP+1];
	div_t                         dv_d   [NSTEP+1];

	logic [CRD_W-1:0]             in_c [MAX_DIMS];
	status_t                      st_in;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= '0;
			for (int i = 0; i < MAX_DIMS; i++)
				stride_q[i] <= IDX_W'(1);
		end else if (cfg_we) begin
			if (cfg_idx == REG_NUM_DIMS) begin
				num_dims_q <= cfg_wdata[DIMS_W-1:0];
			end else if (cfg_idx inside {[REG_STRIDE_0:REG_STRIDE_3]}) begin
				stride_q[2'(cfg_idx - REG_STRIDE_0)] <= cfg_wdata;
			end
		end
	end

	assign dims = (num_dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : num_dims_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// entry checks
	always_comb begin
		in_c[0] = in_req.in_coord_0;
		in_c[1] = in_req.in_coord_1;
		in_c[2] = in_req.in_coord_2;
		in_c[3] = in_req.in_coord_3;
		st_in   = STATUS_OK;
		if (!in_req.mode) begin
			if (in_req.coord_count > dims)
				st_in = STATUS_TOO_MANY;
		end else begin
			for (int i = 0; i < MAX_DIMS; i++)
				if (DIMS_W'(i) < dims && stride_q[i] == '0)
					st_in = STATUS_ZERO_STRIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1.mode <= in_req.mode;
			fr_s1.st   <= st_in;
			fr_s1.rem  <= in_req.in_index;
			for (int i = 0; i < MAX_DIMS; i++)
				c_s1[i] <= (3'(i) < in_req.coord_count) ? in_c[i] : '0;

			fr_s2 <= fr_s1;
			for (int i = 0; i < MAX_DIMS; i++) begin
				plo_s2[i] <= IDX_W'(c_s1[i]) * IDX_W'(stride_q[i][CRD_W-1:0]);
				phi_s2[i] <= CRD_W'(c_s1[i] * stride_q[i][IDX_W-1:CRD_W]);
			end

			fr_s3 <= fr_s2;
			for (int i = 0; i < MAX_DIMS; i++)
				term_s3[i] <= plo_s2[i] + {phi_s2[i], {CRD_W{1'b0}}};

			fr_s4     <= fr_s3;
			sum_s4[0] <= term_s3[0] + term_s3[1];
			sum_s4[1] <= term_s3[2] + term_s3[3];

			fr_s5  <= fr_s4;
			idx_s5 <= sum_s4[0] + sum_s4[1];
		end
	end

	always_comb begin
		dv_d[0].mode = fr_s5.mode;
		dv_d[0].st   = fr_s5.st;
		dv_d[0].idx  = idx_s5;
		dv_d[0].rem  = fr_s5.rem;
		dv_d[0].r    = '0;
		dv_d[0].rh   = '0;
		dv_d[0].q    = '0;
		dv_d[0].crd  = '0;
	end

	// restoring divider, highest dimension first, one quotient bit per stage
	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		localparam int D = MAX_DIMS - 1 - k / IDX_W;
		localparam int J = IDX_W - 1 - k % IDX_W;

		logic [IDX_W-1:0] m;
		logic [IDX_W-1:0] r_in;
		logic [IDX_W-1:0] r_out;
		logic             ge;
		logic             active;

		always_comb begin
			m      = stride_q[D];
			active = DIMS_W'(D) < dims;
			r_in   = (J == IDX_W - 1) ? dv_s[k].rem : dv_s[k].r;
			ge     = (r_in >> J) >= m;
			r_out  = ge ? (r_in - (m << J)) : r_in;

			dv_d[k+1]   = dv_s[k];
			dv_d[k+1].r = r_out;
			if (J == IDX_W - 1)
				dv_d[k+1].q = '0;
			if (J < CRD_W)
				dv_d[k+1].q[J % CRD_W] = ge;
			if (J == CRD_W)
				dv_d[k+1].rh = r_out;
			if (J == 0 && active) begin
				dv_d[k+1].crd[D] = dv_d[k+1].q;
				dv_d[k+1].rem    = dv_s[k].rem - dv_s[k].rh + r_out;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTEP; k++)
				dv_v_s[k] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= v_s5;
			for (int k = 0; k < NSTEP; k++)
				dv_v_s[k+1] <= dv_v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= NSTEP; k++)
				dv_s[k] <= dv_d[k];
		end
	end

	// result formatting
	always_comb begin
		fmt           = '0;
		fmt.status    = dv_s[NSTEP].st;
		if (dv_s[NSTEP].st == STATUS_OK) begin
			if (!dv_s[NSTEP].mode) begin
				fmt.out_index = dv_s[NSTEP].idx;
			end else begin
				fmt.out_coord_0 = dv_s[NSTEP].crd[0];
				fmt.out_coord_1 = dv_s[NSTEP].crd[1];
				fmt.out_coord_2 = dv_s[NSTEP].crd[2];
				fmt.out_coord_3 = dv_s[NSTEP].crd[3];
			end
		end
	end

	// skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready)
				skid_v_q <= 1'b0;
		end else if (dv_v_s[NSTEP] && !out_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && dv_v_s[NSTEP] && !out_ready)
			skid_q <= fmt;
	end

	assign out_valid = skid_v_q || dv_v_s[NSTEP];
	assign out_res   = skid_v_q ? skid_q : fmt;

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost while stalled");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(dv_v_s[NSTEP]))
		else $error("skid filled without a result");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(dv_v_s[NSTEP]))
		else $error("pipeline moved while skid full");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.status != STATUS_OK |-> out_res.out_index == '0
			&& out_res.out_coord_0 == '0 && out_res.out_coord_3 == '0)
		else $error("error result carries data");
endmodule
